// File: sv/mghf_pkg.sv
// mghf_pkg: shared constants, item types and helpers for the masked grid hole fill unit
// no dependencies; imported by mghf_div and masked_grid_hole_fill_dilation_unit
`default_nettype none

package mghf_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int NUM_CH       = 6;     // up r,g,b then down r,g,b
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int RING_ROWS    = 4;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
  localparam int RING_BITS    = $clog2(RING_ROWS);
  localparam int ADDR_BITS    = RING_BITS + COL_BITS;
  localparam int STORE_DEPTH  = RING_ROWS * MAX_WIDTH;
  localparam int SIZE_BITS    = 9;
  localparam int EXT_BITS     = SIZE_BITS + 1;
  localparam int POS_BITS     = 17;
  localparam int CNT_BITS     = 4;     // neighbor count 0..8
  localparam int SUM_BITS     = CHANNEL_BITS + 3;
  localparam int NUM_STEPS    = 9;     // center plus eight neighbors
  localparam int STEP_BITS    = $clog2(NUM_STEPS);
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(NUM_STEPS - 1);

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] chan_vec_t;
  typedef logic [SUM_BITS-1:0] sum_t;
  typedef sum_t [NUM_CH-1:0] sum_vec_t;

  typedef struct packed {
    logic      valid;
    chan_vec_t chans;
  } cell_word_t;

  typedef struct packed {
    logic  is_pad;
    logic  in_valid;
    chan_t in_up_r;
    chan_t in_up_g;
    chan_t in_up_b;
    chan_t in_down_r;
    chan_t in_down_g;
    chan_t in_down_b;
  } cell_item_t;

  typedef struct packed {
    logic  out_valid;
    chan_t out_up_r;
    chan_t out_up_g;
    chan_t out_up_b;
    chan_t out_down_r;
    chan_t out_down_g;
    chan_t out_down_b;
    logic  frame_end;
  } result_item_t;

  typedef struct packed {
    logic                start;
    logic [CNT_BITS-1:0] divisor;
  } div_ctl_t;

  // zero acts as one, oversize saturates
  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                      input logic [SIZE_BITS-1:0] maxv);
    if (v == '0) return SIZE_BITS'(1);
    if (v > maxv) return maxv;
    return v;
  endfunction

  // {row code, column code}, code 0/1/2 means -1/0/+1; step 0 is the center
  function automatic logic [3:0] step_offset(input logic [STEP_BITS-1:0] k);
    logic [3:0] off;
    case (k)
      4'd0:    off = {2'd1, 2'd1};
      4'd1:    off = {2'd0, 2'd0};
      4'd2:    off = {2'd0, 2'd1};
      4'd3:    off = {2'd0, 2'd2};
      4'd4:    off = {2'd1, 2'd0};
      4'd5:    off = {2'd1, 2'd2};
      4'd6:    off = {2'd2, 2'd0};
      4'd7:    off = {2'd2, 2'd1};
      4'd8:    off = {2'd2, 2'd2};
      default: off = {2'd1, 2'd1};
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// File: sv/mghf_div.sv
// mghf_div: six-lane restoring divider, one quotient bit per cycle, shared divisor 1..8
// depends on mghf_pkg
`default_nettype none

module mghf_div (
  input  logic                clk,
  input  logic                rst,
  input  mghf_pkg::div_ctl_t  ctl,
  input  mghf_pkg::sum_vec_t  dividend,
  output logic                done,
  output mghf_pkg::chan_vec_t quotient
);
  import mghf_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0]     divisor;
  sum_vec_t                num;
  sum_vec_t                num_next;
  logic [CNT_BITS-1:0]     rem      [NUM_CH];
  logic [CNT_BITS-1:0]     rem_next [NUM_CH];
  logic [CNT_BITS:0]       trial    [NUM_CH];
  logic [NUM_CH-1:0]       fits;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      trial[i] = {rem[i], num[i][SUM_BITS-1]};
      fits[i]  = trial[i] >= {1'b0, divisor};
      // remainder stays below the divisor, so four bits hold it
      rem_next[i] = fits[i] ? CNT_BITS'(trial[i] - {1'b0, divisor}) : trial[i][CNT_BITS-1:0];
      num_next[i] = {num[i][SUM_BITS-2:0], fits[i]};
      quotient[i] = num[i][CHANNEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_BITS'(SUM_BITS);
      end else if (busy) begin
        count <= count - DIV_CNT_BITS'(1);
        if (count == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num     <= dividend;
      divisor <= ctl.divisor;
      for (int i = 0; i < NUM_CH; i++) rem[i] <= '0;
    end else if (busy) begin
      num <= num_next;
      for (int i = 0; i < NUM_CH; i++) rem[i] <= rem_next[i];
    end
  end

endmodule

`default_nettype wire

// File: sv/masked_grid_hole_fill_dilation_unit.sv
// masked_grid_hole_fill_dilation_unit: one 3x3 masked-average hole fill pass over a raster grid
// depends on mghf_pkg and mghf_div
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------
//   cell     | cell_valid / cell_stall    | sample (mghf_pkg::cell_item_t)
//   result   | result_valid / result_stall| result (mghf_pkg::result_item_t)
//   config   | cfg_we                     | cfg_index, cfg_data
//
// An item that yields no result is taken while the unit stays idle. An item that yields
// a result stalls the input while the unit makes nine reads through the single read port
// of the row store, then runs the bit-serial divider only when a hole with a valid neighbor
// is filled. The row store is not cleared at reset: every entry whose data is used belongs
// to a cell written earlier in the same frame. A stalled result sits in the output register
// while the next item is taken; a second result waits for that slot.
`default_nettype none

module masked_grid_hole_fill_dilation_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cell_valid,
  output logic                             cell_stall,
  input  mghf_pkg::cell_item_t             sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output mghf_pkg::result_item_t           result,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [mghf_pkg::SIZE_BITS-1:0]   cfg_data
);
  import mghf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]           state;
  logic [SIZE_BITS-1:0] grid_width;
  logic [SIZE_BITS-1:0] grid_height;
  logic [SIZE_BITS-1:0] w_eff;
  logic [SIZE_BITS-1:0] h_eff;

  logic [COL_BITS-1:0]  in_col;
  logic [SIZE_BITS-1:0] in_row;
  logic [POS_BITS-1:0]  in_pos;
  logic [COL_BITS-1:0]  out_col;
  logic [ROW_BITS-1:0]  out_row;
  logic                 fr_end;

  logic                 accept;
  logic                 drain;
  logic                 step_live;
  logic                 emit;
  logic                 out_last;
  logic                 col_wrap;
  logic                 load;

  logic [STEP_BITS-1:0] rd_k;
  logic [3:0]           offset;
  logic [EXT_BITS-1:0]  nb_row;
  logic [EXT_BITS-1:0]  nb_col;
  logic                 nb_in_grid;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  cell_word_t           rd_data;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  cell_word_t           wr_word;
  cell_word_t           mem [STORE_DEPTH];

  logic                 tag_live;
  logic [STEP_BITS-1:0] tag_k;
  logic                 tag_inside;
  cell_word_t           center;
  sum_vec_t             sums;
  logic [CNT_BITS-1:0]  nb_cnt;

  div_ctl_t             div_ctl;
  logic                 div_done;
  chan_vec_t            quot;
  chan_vec_t            res_chans;
  result_item_t         result_next;

  assign w_eff = clamp_size(grid_width, SIZE_BITS'(MAX_WIDTH));
  assign h_eff = clamp_size(grid_height, SIZE_BITS'(MAX_HEIGHT));

  assign cell_stall = (state != ST_IDLE);
  assign accept     = cell_valid && !cell_stall;
  assign drain      = in_row >= h_eff;
  // a pad inside the frame is swallowed without advancing
  assign step_live  = accept && (drain || !sample.is_pad);
  assign wr_en      = step_live && !drain;
  assign emit       = step_live && (in_pos >= POS_BITS'(w_eff) + POS_BITS'(1));
  assign out_last   = (SIZE_BITS'(out_row) == h_eff - SIZE_BITS'(1)) &&
                      (SIZE_BITS'(out_col) == w_eff - SIZE_BITS'(1));
  assign col_wrap   = (SIZE_BITS'(in_col) + SIZE_BITS'(1)) >= w_eff;

  assign wr_addr = {in_row[RING_BITS-1:0], in_col};
  assign wr_word = '{valid: sample.in_valid,
                     chans: {sample.in_down_b, sample.in_down_g, sample.in_down_r,
                             sample.in_up_b, sample.in_up_g, sample.in_up_r}};

  // neighbor address; negative offsets wrap high and fail the bounds check
  assign offset     = step_offset(rd_k);
  assign nb_row     = EXT_BITS'(out_row) + EXT_BITS'(offset[3:2]) - EXT_BITS'(1);
  assign nb_col     = EXT_BITS'(out_col) + EXT_BITS'(offset[1:0]) - EXT_BITS'(1);
  assign nb_in_grid = (nb_row < EXT_BITS'(h_eff)) && (nb_col < EXT_BITS'(w_eff));
  assign rd_en      = (state == ST_READ);
  assign rd_addr    = {nb_row[RING_BITS-1:0], nb_col[COL_BITS-1:0]};

  // reads are issued only after the write of the current item has landed
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_live <= 1'b0;
    end else begin
      tag_live <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    tag_k      <= rd_k;
    tag_inside <= nb_in_grid;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sums   <= '0;
      nb_cnt <= '0;
    end else if (tag_live) begin
      if (tag_k == '0) begin
        center <= rd_data;
      end else if (tag_inside && rd_data.valid) begin
        for (int i = 0; i < NUM_CH; i++) sums[i] <= sums[i] + SUM_BITS'(rd_data.chans[i]);
        nb_cnt <= nb_cnt + CNT_BITS'(1);
      end
    end
  end

  assign div_ctl.start   = (state == ST_EVAL) && !center.valid && (nb_cnt != '0);
  assign div_ctl.divisor = nb_cnt;

  mghf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (sums),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (center.valid) begin
      res_chans = center.chans;
    end else if (nb_cnt == '0) begin
      res_chans = '0;
    end else begin
      res_chans = quot;
    end
    result_next.out_valid  = center.valid || (nb_cnt != '0);
    result_next.out_up_r   = res_chans[0];
    result_next.out_up_g   = res_chans[1];
    result_next.out_up_b   = res_chans[2];
    result_next.out_down_r = res_chans[3];
    result_next.out_down_g = res_chans[4];
    result_next.out_down_b = res_chans[5];
    result_next.frame_end  = fr_end;
  end

  assign load = (state == ST_DONE) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      grid_width  <= SIZE_BITS'(MAX_WIDTH);
      grid_height <= SIZE_BITS'(MAX_HEIGHT);
      in_col      <= '0;
      in_row      <= '0;
      in_pos      <= '0;
      out_col     <= '0;
      out_row     <= '0;
      rd_k        <= '0;
      fr_end      <= 1'b0;
    end else if (cfg_we) begin
      // a register write restarts the frame
      if (cfg_index == CFG_GRID_WIDTH) begin
        grid_width <= cfg_data;
      end else begin
        grid_height <= cfg_data;
      end
      in_col  <= '0;
      in_row  <= '0;
      in_pos  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (step_live) begin
        if (emit && out_last) begin
          in_col <= '0;
          in_row <= '0;
          in_pos <= '0;
        end else begin
          in_pos <= in_pos + POS_BITS'(1);
          if (col_wrap) begin
            in_col <= '0;
            in_row <= in_row + SIZE_BITS'(1);
          end else begin
            in_col <= in_col + COL_BITS'(1);
          end
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (emit) begin
            rd_k   <= '0;
            fr_end <= out_last;
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          rd_k <= rd_k + STEP_BITS'(1);
          if (rd_k == STEP_LAST) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (div_ctl.start) begin
            state <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
            if (fr_end) begin
              out_col <= '0;
              out_row <= '0;
            end else if (SIZE_BITS'(out_col) + SIZE_BITS'(1) == w_eff) begin
              out_col <= '0;
              out_row <= out_row + ROW_BITS'(1);
            end else begin
              out_col <= out_col + COL_BITS'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= result_next;
  end

`ifndef SYNTHESIS
  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  // read data is tagged only for reads issued in the previous cycle
  assert property (@(posedge clk) disable iff (rst) tag_live |-> $past(state) == ST_READ)
    else $error("read tag without a preceding read");

  // the cell being worked on lies inside the grid
  assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> (SIZE_BITS'(out_row) < h_eff) && (SIZE_BITS'(out_col) < w_eff))
    else $error("output position outside the grid");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for masked_grid_hole_fill_dilation_unit
// depends on mghf_pkg and the unit; an in-bench copy of the fill pass predicts every
// result item, which is checked field by field in arrival order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mghf_pkg::*;

  localparam int ITEM_TARGET  = 1500;
  localparam int QUIET_CYCLES = 40;
  localparam int STUCK_LIMIT  = 2000;
  localparam int RING_SLOTS   = RING_ROWS * MAX_WIDTH;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cell_valid = 1'b0;
  logic cell_stall;
  cell_item_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_item_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_GRID_WIDTH;
  logic [SIZE_BITS-1:0] cfg_data = '0;

  // predicted copy of the line store, frame position and size registers
  logic ring_ok [RING_SLOTS];
  chan_vec_t ring_ch [RING_SLOTS];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned out_pos = 0;
  logic [SIZE_BITS-1:0] width_reg = 9'd256;
  logic [SIZE_BITS-1:0] height_reg = 9'd256;

  result_item_t fill_expected [$];
  result_item_t pass_out [$];
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned stuck_cycles = 0;
  int unsigned stall_left = 0;
  bit no_idle = 1'b0;

  masked_grid_hole_fill_dilation_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_size(input logic [SIZE_BITS-1:0] v,
                                           input int unsigned lim);
    if (v == '0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned slot_of_cell(input int unsigned r, input int unsigned c);
    return (r % RING_ROWS) * MAX_WIDTH + c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic chan_t rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return chan_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic chan_vec_t rand_chans();
    chan_vec_t v;
    foreach (v[k]) v[k] = rand_chan();
    return v;
  endfunction

  function automatic cell_item_t make_cell(input logic valid, input chan_vec_t v);
    cell_item_t it;
    it.is_pad = 1'b0;
    it.in_valid = valid;
    {it.in_up_r, it.in_up_g, it.in_up_b, it.in_down_r, it.in_down_g, it.in_down_b} = v;
    return it;
  endfunction

  function automatic cell_item_t rand_cell(input int unsigned valid_pct);
    return make_cell($urandom_range(0, 99) < valid_pct, rand_chans());
  endfunction

  function automatic cell_item_t rand_pad();
    cell_item_t it;
    it = rand_cell(50);
    it.is_pad = 1'b1;
    return it;
  endfunction

  // one accepted item through the fill pass; queues the result it releases, if any
  function automatic void fill_predict(input cell_item_t it);
    int unsigned w, h, p, o, r, c, s, ns, cnt;
    int nr, nc, dr, dc, k;
    int unsigned sum [NUM_CH];
    chan_vec_t outv;
    result_item_t res;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    if (row_pos < h) begin
      if (it.is_pad) return;   // pad before the last cell: no effect at all
      s = slot_of_cell(row_pos, col_pos);
      ring_ok[s] = it.in_valid;
      ring_ch[s] = {it.in_up_r, it.in_up_g, it.in_up_b, it.in_down_r, it.in_down_g,
                    it.in_down_b};
    end
    items_sent++;
    p = row_pos * w + col_pos;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (p < w + 1) return;
    o = out_pos;
    r = o / w;
    c = o % w;
    s = slot_of_cell(r, c);
    res = '0;
    outv = '0;
    cnt = 0;
    foreach (sum[i]) sum[i] = 0;
    if (ring_ok[s]) begin
      res.out_valid = 1'b1;
      outv = ring_ch[s];
    end else begin
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          nr = int'(r) + dr;
          nc = int'(c) + dc;
          if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < int'(h) && nc < int'(w)) begin
            ns = slot_of_cell(nr, nc);
            if (ring_ok[ns]) begin
              cnt++;
              for (k = 0; k < NUM_CH; k++) sum[k] += ring_ch[ns][k];
            end
          end
        end
      end
      // a hole with no valid neighbor leaves with zero channels
      if (cnt != 0) begin
        res.out_valid = 1'b1;
        for (k = 0; k < NUM_CH; k++) outv[k] = chan_t'(sum[k] / cnt);
      end
    end
    {res.out_up_r, res.out_up_g, res.out_up_b,
     res.out_down_r, res.out_down_g, res.out_down_b} = outv;
    out_pos++;
    if (o >= w * h - 1) begin
      res.frame_end = 1'b1;
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
    end
    fill_expected.insert(fill_expected.size(), res);
    pass_out.insert(pass_out.size(), res);
  endfunction

  function automatic void field_check(input string name, input logic [CHANNEL_BITS-1:0] want,
                                      input logic [CHANNEL_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(input result_item_t got);
    result_item_t want;
    if (fill_expected.size() == 0) begin
      errors++;
      $display("%0t: result %h arrived with none expected", $time, got);
      return;
    end
    want = fill_expected.pop_front();
    field_check("out_valid", CHANNEL_BITS'(want.out_valid), CHANNEL_BITS'(got.out_valid));
    field_check("out_up_r", want.out_up_r, got.out_up_r);
    field_check("out_up_g", want.out_up_g, got.out_up_g);
    field_check("out_up_b", want.out_up_b, got.out_up_b);
    field_check("out_down_r", want.out_down_r, got.out_down_r);
    field_check("out_down_g", want.out_down_g, got.out_down_g);
    field_check("out_down_b", want.out_down_b, got.out_down_b);
    field_check("frame_end", CHANNEL_BITS'(want.frame_end), CHANNEL_BITS'(got.frame_end));
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      if ((cell_valid && !cell_stall) || (result_valid && !result_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no item moved in %0d cycles", $time, STUCK_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic send_item(input cell_item_t it);
    int unsigned gap;
    cell_valid <= 1'b1;
    sample <= it;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    fill_predict(it);
    gap = pick_gap();
    if (gap != 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending, let every pending result out, then give the unit time to settle
  task automatic hold_until_drained();
    cell_valid <= 1'b0;
    while (fill_expected.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_BITS-1:0] value);
    hold_until_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_WIDTH) width_reg = value;
    else height_reg = value;
    col_pos = 0;
    row_pos = 0;
    out_pos = 0;
  endtask

  task automatic set_size(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
  endtask

  // any item after the last cell only pushes the tail out
  task automatic send_drain(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) send_item(rand_pad());
      else send_item(rand_cell(50));
    end
  endtask

  task automatic send_frame(input int unsigned valid_pct);
    int unsigned w, h;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    pass_out.delete();
    repeat (w * h) begin
      if ($urandom_range(0, 24) == 0) send_item(rand_pad());
      send_item(rand_cell(valid_pct));
      if ($urandom_range(0, 99) == 0) hold_until_drained();
    end
    send_drain(w + 1);
  endtask

  // next dilation pass: the previous frame's results go back in as cells
  task automatic send_pass_back();
    result_item_t prev [$];
    prev = pass_out;
    pass_out.delete();
    foreach (prev[i]) begin
      send_item(make_cell(prev[i].out_valid,
                          {prev[i].out_up_r, prev[i].out_up_g, prev[i].out_up_b,
                           prev[i].out_down_r, prev[i].out_down_g, prev[i].out_down_b}));
    end
    send_drain(eff_size(width_reg, MAX_WIDTH) + 1);
  endtask

  task automatic test_basic_fill();
    set_size(9'd3, 9'd3);
    send_item(make_cell(1'b1, '1));
    send_item(make_cell(1'b0, rand_chans()));
    send_item(make_cell(1'b0, rand_chans()));   // no valid neighbor, stays a hole
    send_item(make_cell(1'b1, rand_chans()));
    send_item(make_cell(1'b0, '1));             // hole data is ignored
    send_item(rand_pad());                      // pad inside the frame is dropped
    send_item(make_cell(1'b0, rand_chans()));
    send_item(make_cell(1'b0, '0));
    send_item(make_cell(1'b0, rand_chans()));
    send_item(make_cell(1'b1, '0));
    send_item(rand_pad());
    send_item(make_cell(1'b1, rand_chans()));   // cell during drain
    send_item(rand_pad());
    send_item(rand_pad());
  endtask

  task automatic test_size_clamp();
    set_size(9'd0, 9'd0);
    send_item(make_cell(1'b0, rand_chans()));
    send_drain(2);
    send_item(make_cell(1'b1, rand_chans()));
    send_drain(2);
  endtask

  task automatic test_restart_midframe();
    set_size(9'd2, 9'd2);
    send_item(make_cell(1'b1, '1));
    send_item(make_cell(1'b1, '1));
    // partial frame, nothing out yet; the write throws it away
    write_reg(CFG_GRID_HEIGHT, 9'd2);
    send_frame(50);
  endtask

  task automatic test_size_extremes();
    set_size(9'd511, 9'd0);
    send_frame(40);
    set_size(9'd0, 9'd256);
    send_frame(40);
    set_size(9'd1, 9'd300);
    send_frame(70);
  endtask

  function automatic logic [SIZE_BITS-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return SIZE_BITS'($urandom_range(1, 6));
    if (roll < 92) return SIZE_BITS'($urandom_range(7, 16));
    if (roll < 97) return '0;
    return SIZE_BITS'($urandom_range(17, 32));
  endfunction

  task automatic test_random_frames();
    int unsigned valid_pct, passes;
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      set_size(pick_size(), pick_size());
      case ($urandom_range(0, 3))
        0: valid_pct = 5;
        1: valid_pct = 30;
        2: valid_pct = 60;
        default: valid_pct = 95;
      endcase
      send_frame(valid_pct);
      // a random third of the frames run extra passes so the fill spreads
      passes = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
      repeat (passes) send_pass_back();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_basic_fill();
    test_size_clamp();
    test_restart_midframe();
    test_size_extremes();
    test_random_frames();
    hold_until_drained();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
